// ===== design/dsu_pkg.sv =====
// Shared constants, types and state codes of the disjoint-set engine.
`default_nettype none
package dsu_pkg;

    localparam int IDX_W        = 10;
    localparam int NUM_ELEMENTS = 2 ** IDX_W;
    localparam int RANK_W       = 4;
    localparam int CNT_W        = IDX_W + 1;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [RANK_W-1:0] RANK_MAX     = {RANK_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_RESET  = CNT_W'(NUM_ELEMENTS);

    // Register index of the element count in the register map.
    localparam logic [APB_AW-3:0] REG_ELEMENT_COUNT = '0;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNITE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_LINK
    } t_state;

    // Memory requests from the sequencer; both tables share the read address.
    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              par_we;
        logic [IDX_W-1:0]  par_waddr;
        logic [IDX_W-1:0]  par_wdata;
        logic              rank_we;
        logic [IDX_W-1:0]  rank_waddr;
        logic [RANK_W-1:0] rank_wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== design/dsu_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module dsu_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/dsu_ctrl.sv =====
// Sequencer: clearing pass, root walks, path compression and linking by rank.
`default_nettype none
module dsu_ctrl
    import dsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_op,
    input  wire logic [IDX_W-1:0]  i_first_index,
    input  wire logic [IDX_W-1:0]  i_second_index,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [IDX_W-1:0]  i_par_rdata,
    input  wire logic [RANK_W-1:0] i_rank_rdata,
    output t_mem_req               o_mem,
    output logic                   o_busy,
    output logic                   o_valid,
    output logic [IDX_W-1:0]       o_root,
    output logic                   o_merged,
    output logic                   o_index_error
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic              r_op, n_op;
    logic              r_second, n_second;
    logic [IDX_W-1:0]  r_a, n_a;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_root, n_root;
    logic [IDX_W-1:0]  r_pa, n_pa;
    logic [RANK_W-1:0] r_rank_a, n_rank_a;
    logic [RANK_W-1:0] r_rank_b, n_rank_b;
    logic              r_valid, n_valid;
    logic [IDX_W-1:0]  r_out_root, n_out_root;
    logic              r_merged, n_merged;
    logic              r_err, n_err;
    logic              w_a_ok, w_b_ok;
    logic [IDX_W-1:0]  w_start_idx;

    assign w_a_ok = {1'b0, i_first_index} < i_count;
    assign w_b_ok = {1'b0, i_second_index} < i_count;
    assign w_start_idx = r_second ? r_b : r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_second   <= n_second;
        r_a        <= n_a;
        r_b        <= n_b;
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_pa       <= n_pa;
        r_rank_a   <= n_rank_a;
        r_rank_b   <= n_rank_b;
        r_out_root <= n_out_root;
        r_merged   <= n_merged;
        r_err      <= n_err;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_second   = r_second;
        n_a        = r_a;
        n_b        = r_b;
        n_cur      = r_cur;
        n_root     = r_root;
        n_pa       = r_pa;
        n_rank_a   = r_rank_a;
        n_rank_b   = r_rank_b;
        n_valid    = 1'b0;
        n_out_root = r_out_root;
        n_merged   = r_merged;
        n_err      = r_err;
        o_mem      = '0;
        o_mem.rd_addr = r_cur;

        case (r_state)
            S_CLEAR: begin
                o_mem.par_we     = 1'b1;
                o_mem.par_waddr  = r_clr;
                o_mem.par_wdata  = r_clr;
                o_mem.rank_we    = 1'b1;
                o_mem.rank_waddr = r_clr;
                o_mem.rank_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (!w_a_ok || (i_op == OP_UNITE && !w_b_ok)) begin
                        n_valid    = 1'b1;
                        n_out_root = '0;
                        n_merged   = 1'b0;
                        n_err      = 1'b1;
                    end else begin
                        n_op     = i_op;
                        n_a      = i_first_index;
                        n_b      = i_second_index;
                        n_second = 1'b0;
                        n_cur    = i_first_index;
                        o_mem.rd_addr = i_first_index;
                        n_state  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // The read data is the parent of r_cur; a self-parent is the root.
                if (i_par_rdata == r_cur) begin
                    n_root = r_cur;
                    if (r_second) begin
                        n_rank_b = i_rank_rdata;
                    end else begin
                        n_rank_a = i_rank_rdata;
                    end
                    n_cur = w_start_idx;
                    o_mem.rd_addr = w_start_idx;
                    n_state = S_COMP;
                end else begin
                    n_cur = i_par_rdata;
                    o_mem.rd_addr = i_par_rdata;
                end
            end
            S_COMP: begin
                if (r_cur == r_root) begin
                    if (r_op == OP_FIND) begin
                        n_valid    = 1'b1;
                        n_out_root = r_root;
                        n_merged   = 1'b0;
                        n_err      = 1'b0;
                        n_state    = S_IDLE;
                    end else if (!r_second) begin
                        n_pa     = r_root;
                        n_second = 1'b1;
                        n_cur    = r_b;
                        o_mem.rd_addr = r_b;
                        n_state  = S_WALK;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    // Point this path node at the root and follow its old parent.
                    o_mem.par_we    = 1'b1;
                    o_mem.par_waddr = r_cur;
                    o_mem.par_wdata = r_root;
                    n_cur = i_par_rdata;
                    o_mem.rd_addr = i_par_rdata;
                end
            end
            S_LINK: begin
                n_valid = 1'b1;
                n_err   = 1'b0;
                n_state = S_IDLE;
                if (r_pa == r_root) begin
                    n_out_root = r_pa;
                    n_merged   = 1'b0;
                end else begin
                    n_merged = 1'b1;
                    o_mem.par_we = 1'b1;
                    if (r_rank_a < r_rank_b) begin
                        o_mem.par_waddr = r_pa;
                        o_mem.par_wdata = r_root;
                        n_out_root      = r_root;
                    end else begin
                        o_mem.par_waddr = r_root;
                        o_mem.par_wdata = r_pa;
                        n_out_root      = r_pa;
                        if (r_rank_a == r_rank_b && r_rank_a != RANK_MAX) begin
                            o_mem.rank_we    = 1'b1;
                            o_mem.rank_waddr = r_pa;
                            o_mem.rank_wdata = r_rank_a + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_root        = r_out_root;
    assign o_merged      = r_merged;
    assign o_index_error = r_err;

    // Compression never reads the entry it is rewriting in the same cycle.
    a_comp_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && o_mem.par_we) |-> (o_mem.par_waddr != o_mem.rd_addr))
        else $error("compression write collides with read");

    // No result leaves the block during the clearing pass.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_valid)
        else $error("result during clearing pass");

    // A merge is never reported together with an index error.
    a_merge_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_merged) |-> !r_err)
        else $error("merge flagged with index error");

    // Linking always ends in a result in the next cycle.
    a_link_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (r_valid && r_state == S_IDLE))
        else $error("link did not produce a result");

endmodule
`default_nettype wire

// ===== design/disjoint_set_union_find.sv =====
// Top level of the disjoint-set engine: register port, tables and sequencer.
//
// After reset the block initialises its tables, one entry a cycle,
// with busy high; register writes are taken throughout. An item is
// taken when start is high and busy is low. A find walks from its
// element up to the root and then compresses the path; a unite does
// the same for both elements and then links the roots by rank if they differ.
// Busy falls in the cycle that o_valid rises. The pace is set by the
// single read port of the parent table: the root walk and the path
// compression each visit one node a cycle. An item with an index that
// it uses at or beyond the element count is answered in the next cycle.
// Each result is shown for one cycle with o_valid high and is not held,
// since the receiver cannot stall.
`default_nettype none
module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_op,
    input  wire logic [IDX_W-1:0]  i_first_index,
    input  wire logic [IDX_W-1:0]  i_second_index,
    output logic                   o_valid,
    output logic      [IDX_W-1:0]  o_root,
    output logic                   o_merged,
    output logic                   o_index_error
);

    logic [CNT_W-1:0]  r_count;
    logic              w_reg_hit;
    logic              w_wr;
    t_mem_req          w_mem;
    logic [IDX_W-1:0]  w_par_rdata;
    logic [RANK_W-1:0] w_rank_rdata;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_AW-1:2] == REG_ELEMENT_COUNT);
    assign w_wr      = psel && penable && pwrite && pready && w_reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (w_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = w_reg_hit ? {{(APB_DW-CNT_W){1'b0}}, r_count} : '0;

    dsu_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.par_we),
        .i_waddr (w_mem.par_waddr),
        .i_wdata (w_mem.par_wdata),
        .i_raddr (w_mem.rd_addr),
        .o_rdata (w_par_rdata)
    );

    dsu_ram #(
        .WIDTH (RANK_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.rank_we),
        .i_waddr (w_mem.rank_waddr),
        .i_wdata (w_mem.rank_wdata),
        .i_raddr (w_mem.rd_addr),
        .o_rdata (w_rank_rdata)
    );

    dsu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .i_count        (r_count),
        .i_par_rdata    (w_par_rdata),
        .i_rank_rdata   (w_rank_rdata),
        .o_mem          (w_mem),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_root         (o_root),
        .o_merged       (o_merged),
        .o_index_error  (o_index_error)
    );

endmodule
`default_nettype wire

// ===== tb/disjoint_set_union_find_tb.sv =====
// Self-checking testbench for the disjoint-set engine: directed items, then random phases.
`timescale 1ns / 100ps

import dsu_pkg::*;

class set_forest;
    logic [IDX_W-1:0]  parent_of [NUM_ELEMENTS];
    logic [RANK_W-1:0] rank_of   [NUM_ELEMENTS];
    logic [CNT_W-1:0]  element_count;
    logic [IDX_W-1:0]  awaited_root [$];
    logic              awaited_merged [$];
    logic              awaited_error [$];
    int                mismatches;
    int                finds;
    int                unites;
    int                merges;
    int                index_errors;

    function new();
        for (int i = 0; i < NUM_ELEMENTS; i++) begin
            parent_of[i] = IDX_W'(i);
            rank_of[i]   = '0;
        end
        element_count = COUNT_RESET;
        mismatches    = 0;
        finds         = 0;
        unites        = 0;
        merges        = 0;
        index_errors  = 0;
    endfunction

    function int pending();
        return awaited_root.size();
    endfunction

    function bit in_range(logic [IDX_W-1:0] idx);
        return {1'b0, idx} < element_count;
    endfunction

    // Walks up to the root, then points every node passed straight at it.
    function logic [IDX_W-1:0] root_of(logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] nxt;
        int               steps;
        r     = x;
        steps = 0;
        while (parent_of[r] != r && steps < NUM_ELEMENTS) begin
            r = parent_of[r];
            steps++;
        end
        c     = x;
        steps = 0;
        while (c != r && steps < NUM_ELEMENTS) begin
            nxt          = parent_of[c];
            parent_of[c] = r;
            c            = nxt;
            steps++;
        end
        return r;
    endfunction

    function void note_item(logic op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] root;
        logic             merged;
        logic             index_error;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        root        = '0;
        merged      = 1'b0;
        index_error = 1'b0;
        if (op == OP_FIND) begin
            finds++;
            if (!in_range(a))
                index_error = 1'b1;
            else
                root = root_of(a);
        end else begin
            unites++;
            if (!in_range(a) || !in_range(b)) begin
                index_error = 1'b1;
            end else begin
                ra = root_of(a);
                rb = root_of(b);
                if (ra == rb) begin
                    root = ra;
                end else begin
                    merged = 1'b1;
                    if (rank_of[ra] < rank_of[rb]) begin
                        parent_of[ra] = rb;
                        root          = rb;
                    end else begin
                        // On a tie the first root survives and its rank grows unless already at RANK_MAX.
                        if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
                            rank_of[ra] = rank_of[ra] + 1'b1;
                        parent_of[rb] = ra;
                        root          = ra;
                    end
                end
            end
        end
        merges       += merged;
        index_errors += index_error;
        awaited_root   = {awaited_root, root};
        awaited_merged = {awaited_merged, merged};
        awaited_error  = {awaited_error, index_error};
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", what);
    endtask

    task check_answer(logic [IDX_W-1:0] root, logic merged, logic index_error);
        logic [IDX_W-1:0] want_root;
        logic             want_merged;
        logic             want_error;
        if (awaited_root.size() == 0) begin
            report_mismatch($sformatf("result root=%0d merged=%0b error=%0b with no item open",
                                      root, merged, index_error));
        end else begin
            want_root   = awaited_root.pop_front();
            want_merged = awaited_merged.pop_front();
            want_error  = awaited_error.pop_front();
            if (root !== want_root)
                report_mismatch($sformatf("root %0d, expected %0d", root, want_root));
            if (merged !== want_merged)
                report_mismatch($sformatf("merged %0b, expected %0b", merged, want_merged));
            if (index_error !== want_error)
                report_mismatch($sformatf("index_error %0b, expected %0b",
                                          index_error, want_error));
        end
    endtask
endclass

module disjoint_set_union_find_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASES       = 10;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [APB_AW-1:0] paddr          = '0;
    logic [APB_DW-1:0] pwdata         = '0;
    logic              start          = 1'b0;
    logic              i_op           = OP_FIND;
    logic [IDX_W-1:0]  i_first_index  = '0;
    logic [IDX_W-1:0]  i_second_index = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              busy;
    logic              o_valid;
    logic [IDX_W-1:0]  o_root;
    logic              o_merged;
    logic              o_index_error;

    set_forest forest;
    int        stall_cycles = 0;
    int        count_writes = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    disjoint_set_union_find u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .o_valid        (o_valid),
        .o_root         (o_root),
        .o_merged       (o_merged),
        .o_index_error  (o_index_error)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            forest.check_answer(o_root, o_merged, o_index_error);
    end

    // Ends the run if neither an item nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [IDX_W-1:0] a,
                             input logic [IDX_W-1:0] b);
        start          <= 1'b1;
        i_op           <= op;
        i_first_index  <= a;
        i_second_index <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        forest.note_item(op, a, b);
    endtask

    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (forest.pending() != 0);
    endtask

    // Writes the element count, then reads it back in the very next transfer.
    task automatic set_element_count(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ELEMENT_COUNT, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        forest.element_count = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DW'(value))
            forest.report_mismatch($sformatf("element count reads back %0d, written %0d",
                                             prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        count_writes++;
    endtask

    function automatic logic [CNT_W-1:0] phase_count(input int p);
        case (p)
            0:       return 11'd1024;
            1:       return 11'd300;
            2:       return 11'd37;
            3:       return 11'd2047;
            4:       return 11'd1;
            5:       return 11'd0;
            6:       return 11'd2;
            7:       return 11'd512;
            8:       return 11'd1000;
            default: return 11'd1024;
        endcase
    endfunction

    function automatic int phase_items(input int p);
        case (p)
            0:       return 250;
            4:       return 60;
            5:       return 40;
            6:       return 60;
            9:       return 240;
            default: return 150;
        endcase
    endfunction

    // Mostly indices in range, with a hot window so that sets grow deep.
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned span;
        int unsigned roll;
        span = (forest.element_count > NUM_ELEMENTS) ? NUM_ELEMENTS : forest.element_count;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 8)
            return IDX_W'($urandom_range(0, NUM_ELEMENTS - 1));
        if (roll < 12)
            return roll[0] ? IDX_W'(span - 1) : IDX_W'(span);
        if (roll < 40 && span > 64)
            return IDX_W'($urandom_range(0, 63));
        return IDX_W'($urandom_range(0, span - 1));
    endfunction

    initial begin
        int               gap_odds;
        logic             op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;

        forest = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_element_count(11'd1024);

        // Extremes of the index range, tie and unequal-rank links, a
        // self-union and a repeat unite of elements already joined.
        send_item(OP_FIND, 10'd0, 10'd0);
        send_item(OP_FIND, 10'd1023, 10'd0);
        send_item(OP_UNITE, 10'd0, 10'd1);
        send_item(OP_UNITE, 10'd2, 10'd3);
        idle_burst(3);
        send_item(OP_UNITE, 10'd1, 10'd3);
        send_item(OP_FIND, 10'd3, 10'd1023);
        send_item(OP_UNITE, 10'd3, 10'd0);
        send_item(OP_UNITE, 10'd5, 10'd5);
        send_item(OP_UNITE, 10'd1023, 10'd1022);
        send_item(OP_UNITE, 10'd1022, 10'd2);
        send_item(OP_UNITE, 10'd7, 10'd4);
        send_item(OP_UNITE, 10'd6, 10'd7);
        send_item(OP_UNITE, 10'd1000, 10'd9);

        // With the count lowered, element 9 keeps a root above the count.
        wait_drained();
        set_element_count(11'd16);
        send_item(OP_FIND, 10'd16, 10'd0);
        send_item(OP_FIND, 10'd9, 10'd0);
        send_item(OP_UNITE, 10'd10, 10'd9);
        send_item(OP_UNITE, 10'd3, 10'd20);
        send_item(OP_UNITE, 10'd20, 10'd3);
        send_item(OP_FIND, 10'd15, 10'd0);

        wait_drained();
        set_element_count(11'd0);
        send_item(OP_FIND, 10'd0, 10'd0);

        wait_drained();
        set_element_count(11'd2047);
        send_item(OP_FIND, 10'd1023, 10'd0);
        send_item(OP_UNITE, 10'd1023, 10'd0);

        wait_drained();
        set_element_count(11'd1);
        send_item(OP_FIND, 10'd0, 10'd0);
        send_item(OP_UNITE, 10'd0, 10'd1);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_element_count(phase_count(p));
            // Odd phases and the last one run back to back with no gaps.
            gap_odds = (p % 2 == 1 || p == PHASES - 1) ? 0 : 25;
            for (int n = 0; n < phase_items(p); n++) begin
                op = ($urandom_range(0, 99) < 55) ? OP_UNITE : OP_FIND;
                a  = pick_index();
                b  = pick_index();
                send_item(op, a, b);
                if (p == 0 && n == 120)
                    wait_drained();
                else if ($urandom_range(0, 99) < gap_odds)
                    idle_burst($urandom_range(1, 12));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d finds and %0d unites, %0d merges, %0d index errors",
                 forest.finds, forest.unites, forest.merges, forest.index_errors);
        $display("element count written and read back %0d times, from 0 up to 2047",
                 count_writes);
        if (forest.mismatches == 0 && forest.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dsu_pkg.sv
design/dsu_ram.sv
design/dsu_ctrl.sv
design/disjoint_set_union_find.sv
tb/disjoint_set_union_find_tb.sv
